// File: hw/rtl/dsht_pkg.sv
// dsht_pkg: shared types, constants and the frame builder of the dshot transmitter
// used by every module of the block, depends on nothing

package dsht_pkg;

  localparam int unsigned MOTOR_COUNT = 4;
  localparam int unsigned FRAME_BITS  = 16;
  localparam int unsigned BIT_W       = $clog2(FRAME_BITS);
  localparam int unsigned LINE_W      = 4;
  localparam int unsigned TIME_W      = 16;
  localparam int unsigned IDX_W       = 2;
  localparam int unsigned VALUE_W     = 11;
  localparam int unsigned MODE_W      = 2;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned IN_DATA_W   = 16;
  localparam int unsigned OUT_DATA_W  = 8;

  localparam logic [TIME_W-1:0] BIT_PERIOD_RST = 16'd79;
  localparam logic [TIME_W-1:0] HIGH_ZERO_RST  = 16'd23;
  localparam logic [TIME_W-1:0] HIGH_ONE_RST   = 16'd47;
  localparam logic [BIT_W-1:0]  LAST_BIT       = BIT_W'(FRAME_BITS - 1);

  typedef enum logic [MODE_W-1:0] {
    MODE_TICK  = 2'd0,
    MODE_STORE = 2'd1,
    MODE_START = 2'd2
  } mode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BIT_PERIOD = 2'd0,
    CFG_HIGH_ZERO  = 2'd1,
    CFG_HIGH_ONE   = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    logic [TIME_W-1:0] bit_period;
    logic [TIME_W-1:0] high_zero;
    logic [TIME_W-1:0] high_one;
  } cfg_t;

  typedef struct packed {
    logic                  tick;
    logic                  store;
    logic                  start;
    logic [IDX_W-1:0]      motor_index;
    logic [FRAME_BITS-1:0] frame;
  } cmd_t;

  typedef struct packed {
    logic sending;
    logic below_one;
    logic below_zero;
    logic shift_en;
    logic done;
  } tmr_stat_t;

  typedef struct packed {
    logic              start_dropped;
    logic              frame_done;
    logic              busy_res;
    logic [LINE_W-1:0] motor_lines;
  } result_t;

  // value and telemetry bit on top, xor of the three nibbles below
  function automatic logic [FRAME_BITS-1:0] build_frame(logic [VALUE_W-1:0] value,
                                                        logic tel);
    logic [VALUE_W:0] word;
    logic [3:0]       csum;
    word = {value, tel};
    csum = word[3:0] ^ word[7:4] ^ word[11:8];
    return {word, csum};
  endfunction

endpackage

// File: hw/rtl/dshot_four_channel_transmitter_top.sv
// dshot_four_channel_transmitter_top: input register, command decode, config and result
// register; depends on dsht_pkg, dsht_bit_timer and dsht_frame_store
//
// channel   direction  handshake              payload
// s_axis    in         tvalid / tready        tdata frame fields, tuser mode
// m_axis    out        tvalid / tready        tdata result fields
// cfg       in         cfg_valid / cfg_ready  register index and 16-bit value
//
// one item per cycle sustained while m_axis_tready holds: input register, one pass of
// decode, timer and line logic, then the result register
// the input register takes a new item while the result register still waits
// reset clears all frames, counters and valid flags at once, config to its defaults
// config writes are always taken

module dshot_four_channel_transmitter_top #(
  parameter int unsigned MOTOR_COUNT = dsht_pkg::MOTOR_COUNT
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // motor_index, throttle_value, telemetry_request, zero pad
  input  logic [dsht_pkg::IN_DATA_W-1:0]     s_axis_tdata,
  // mode
  input  logic [dsht_pkg::MODE_W-1:0]        s_axis_tuser,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // motor_lines, busy_res, frame_done, start_dropped, zero pad
  output logic [dsht_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [dsht_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [dsht_pkg::TIME_W-1:0]        cfg_data_i
);

  logic                              in_valid_q, in_valid_d;
  logic [dsht_pkg::IN_DATA_W-1:0]    in_data_q;
  logic [dsht_pkg::MODE_W-1:0]       in_mode_q;
  logic                              out_valid_q, out_valid_d;
  dsht_pkg::result_t                 res_q, res_d;
  dsht_pkg::cfg_t                    cfg_q;
  dsht_pkg::cmd_t                    cmd;
  dsht_pkg::tmr_stat_t               stat;
  logic [dsht_pkg::LINE_W-1:0]       lines;
  logic                              advance;
  logic                              proc;
  logic                              s_acc;

  assign advance       = !out_valid_q || m_axis_tready;
  assign s_axis_tready = !in_valid_q || advance;
  assign s_acc         = s_axis_tvalid && s_axis_tready;
  assign proc          = in_valid_q && advance;
  assign cfg_ready_o   = 1'b1;

  always_comb begin
    in_valid_d = in_valid_q;
    if (s_acc) begin
      in_valid_d = 1'b1;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (proc) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_comb begin
    cmd.tick        = proc && (in_mode_q == dsht_pkg::MODE_TICK);
    cmd.store       = proc && (in_mode_q == dsht_pkg::MODE_STORE);
    cmd.start       = proc && (in_mode_q == dsht_pkg::MODE_START) && !stat.sending;
    cmd.motor_index = in_data_q[dsht_pkg::IDX_W-1:0];
    cmd.frame       = dsht_pkg::build_frame(
                        in_data_q[dsht_pkg::IDX_W +: dsht_pkg::VALUE_W],
                        in_data_q[dsht_pkg::IDX_W + dsht_pkg::VALUE_W]);
  end

  dsht_bit_timer u_timer (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_q),
    .cmd_i  (cmd),
    .stat_o (stat)
  );

  dsht_frame_store #(
    .MOTOR_COUNT (MOTOR_COUNT)
  ) u_store (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cmd_i   (cmd),
    .stat_i  (stat),
    .lines_o (lines)
  );

  always_comb begin
    res_d.motor_lines   = lines;
    res_d.busy_res      = cmd.start || stat.sending;
    res_d.frame_done    = stat.done;
    res_d.start_dropped = proc && (in_mode_q == dsht_pkg::MODE_START) && stat.sending;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {1'b0, res_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_acc) begin
      in_data_q <= s_axis_tdata;
      in_mode_q <= s_axis_tuser;
    end
    if (proc) begin
      res_q <= res_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.bit_period <= dsht_pkg::BIT_PERIOD_RST;
      cfg_q.high_zero  <= dsht_pkg::HIGH_ZERO_RST;
      cfg_q.high_one   <= dsht_pkg::HIGH_ONE_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        dsht_pkg::CFG_BIT_PERIOD: cfg_q.bit_period <= cfg_data_i;
        dsht_pkg::CFG_HIGH_ZERO:  cfg_q.high_zero  <= cfg_data_i;
        dsht_pkg::CFG_HIGH_ONE:   cfg_q.high_one   <= cfg_data_i;
        default: ;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_done_while_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && res_q.frame_done |-> res_q.busy_res)
    else $error("frame end reported while idle");

  a_drop_while_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && res_q.start_dropped |-> res_q.busy_res)
    else $error("dropped start reported while idle");

  a_done_drop_apart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(res_q.frame_done && res_q.start_dropped))
    else $error("frame end and dropped start on one item");

  a_idle_lines_low: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !res_q.busy_res && !res_q.frame_done |-> res_q.motor_lines == '0)
    else $error("lines driven while idle");
`endif

endmodule

// File: hw/rtl/dsht_bit_timer.sv
// dsht_bit_timer: tick counter, bit counter and busy flag of the frame sender
// depends on dsht_pkg

module dsht_bit_timer (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  dsht_pkg::cfg_t     cfg_i,
  input  dsht_pkg::cmd_t     cmd_i,
  output dsht_pkg::tmr_stat_t stat_o
);

  logic                         sending_q, sending_d;
  logic [dsht_pkg::BIT_W-1:0]   bit_q, bit_d;
  logic [dsht_pkg::TIME_W-1:0]  tick_q, tick_d;
  logic [dsht_pkg::TIME_W-1:0]  tick_eff;
  logic                         shift_en;
  logic                         done;

  always_comb begin
    sending_d = sending_q;
    bit_d     = bit_q;
    tick_d    = tick_q;
    shift_en  = 1'b0;
    done      = 1'b0;
    if (cmd_i.start) begin
      sending_d = 1'b1;
      bit_d     = '0;
      tick_d    = '0;
    end else if (cmd_i.tick && sending_q) begin
      if (tick_q >= cfg_i.bit_period) begin
        tick_d   = '0;
        shift_en = 1'b1;
        if (bit_q == dsht_pkg::LAST_BIT) begin
          bit_d     = '0;
          sending_d = 1'b0;
          done      = 1'b1;
        end else begin
          bit_d = bit_q + 1'b1;
        end
      end else begin
        tick_d = tick_q + 1'b1;
      end
    end
  end

  // a fresh start shows tick zero of the first bit
  assign tick_eff = cmd_i.start ? '0 : tick_q;

  always_comb begin
    stat_o.sending    = sending_q;
    stat_o.below_one  = tick_eff < cfg_i.high_one;
    stat_o.below_zero = tick_eff < cfg_i.high_zero;
    stat_o.shift_en   = shift_en;
    stat_o.done       = done;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sending_q <= 1'b0;
      bit_q     <= '0;
      tick_q    <= '0;
    end else begin
      sending_q <= sending_d;
      bit_q     <= bit_d;
      tick_q    <= tick_d;
    end
  end

`ifndef SYNTHESIS
  a_done_goes_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done |=> !sending_q)
    else $error("timer still busy after frame end");

  a_idle_counters_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !sending_q |-> (bit_q == '0) && (tick_q == '0))
    else $error("timer counters not cleared while idle");
`endif

endmodule

// File: hw/rtl/dsht_frame_store.sv
// dsht_frame_store: staging and shift registers per motor, and the line levels
// depends on dsht_pkg

module dsht_frame_store #(
  parameter int unsigned MOTOR_COUNT = dsht_pkg::MOTOR_COUNT
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  dsht_pkg::cmd_t              cmd_i,
  input  dsht_pkg::tmr_stat_t         stat_i,
  output logic [dsht_pkg::LINE_W-1:0] lines_o
);

  logic [dsht_pkg::FRAME_BITS-1:0] staged_q [MOTOR_COUNT];
  logic [dsht_pkg::FRAME_BITS-1:0] shift_q  [MOTOR_COUNT];
  logic                            active;

  assign active = cmd_i.start || stat_i.sending;

  for (genvar k = 0; k < MOTOR_COUNT; k++) begin : g_motor
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        staged_q[k] <= '0;
        shift_q[k]  <= '0;
      end else begin
        if (cmd_i.store && ({1'b0, cmd_i.motor_index} == 3'(k))) begin
          staged_q[k] <= cmd_i.frame;
        end
        if (cmd_i.start) begin
          shift_q[k] <= staged_q[k];
        end else if (stat_i.shift_en) begin
          shift_q[k] <= {shift_q[k][dsht_pkg::FRAME_BITS-2:0], 1'b0};
        end
      end
    end
  end

  for (genvar k = 0; k < dsht_pkg::LINE_W; k++) begin : g_line
    if (k < MOTOR_COUNT) begin : g_used
      logic msb;
      assign msb = cmd_i.start ? staged_q[k][dsht_pkg::FRAME_BITS-1]
                               : shift_q[k][dsht_pkg::FRAME_BITS-1];
      assign lines_o[k] = active && stat_i.below_one && (msb || stat_i.below_zero);
    end else begin : g_unused
      assign lines_o[k] = 1'b0;
    end
  end

endmodule
